// ===== rtl/mhsp_pkg.sv =====
// Shared types and constants for the MQTT header stream parser.
package mhsp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ROLE_W  = 3;
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned QOS_W   = 2;
  localparam int unsigned LEN_W   = 28;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned NEED_W  = 17;
  localparam int unsigned LCNT_W  = 3;

  // Length bytes allowed before the length field is cut off as overlong (1..4).
  localparam logic [LCNT_W-1:0] MAX_LEN_BYTES = 3'd4;

  localparam logic [TYPE_W-1:0] TYPE_PUBLISH = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_ID_LO   = 4'd4;
  localparam logic [TYPE_W-1:0] TYPE_ID_HI   = 4'd11;

  localparam logic [6:0]        LEN_GROUP_MASK = 7'h7f;
  localparam logic [QOS_W-1:0]  QOS_NONE       = 2'd0;

  typedef logic [ROLE_W-1:0] role_t;
  localparam role_t ROLE_TYPE    = 3'd0;
  localparam role_t ROLE_LEN     = 3'd1;
  localparam role_t ROLE_TLEN    = 3'd2;
  localparam role_t ROLE_TOPIC   = 3'd3;
  localparam role_t ROLE_ID      = 3'd4;
  localparam role_t ROLE_PAYLOAD = 3'd5;
  localparam role_t ROLE_OTHER   = 3'd6;

  typedef enum logic [6:0] {
    PH_TYPE    = 7'b0000001,
    PH_LEN     = 7'b0000010,
    PH_TLEN    = 7'b0000100,
    PH_TOPIC   = 7'b0001000,
    PH_ID      = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_OTHER   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    role_t             byte_role;
    logic              header_done;
    logic [TYPE_W-1:0] packet_type;
    logic [QOS_W-1:0]  qos_level;
    logic [LEN_W-1:0]  remaining_length;
    logic [WORD_W-1:0] topic_length;
    logic [WORD_W-1:0] packet_id;
    logic              has_packet_id;
    logic [LEN_W-1:0]  payload_length;
    logic              last_of_packet;
    logic              malformed;
  } result_t;

endpackage

// ===== rtl/mhsp_if.sv =====
// Byte and result channel interfaces for the MQTT header stream parser.
interface mhsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [mhsp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mhsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mhsp_pkg::BYTE_W-1:0] byte_out;
  mhsp_pkg::role_t             byte_role;
  logic                        header_done;
  logic [mhsp_pkg::TYPE_W-1:0] packet_type;
  logic [mhsp_pkg::QOS_W-1:0]  qos_level;
  logic [mhsp_pkg::LEN_W-1:0]  remaining_length;
  logic [mhsp_pkg::WORD_W-1:0] topic_length;
  logic [mhsp_pkg::WORD_W-1:0] packet_id;
  logic                        has_packet_id;
  logic [mhsp_pkg::LEN_W-1:0]  payload_length;
  logic                        last_of_packet;
  logic                        malformed;

  modport source (output valid, output byte_out, output byte_role, output header_done,
                  output packet_type, output qos_level, output remaining_length,
                  output topic_length, output packet_id, output has_packet_id,
                  output payload_length, output last_of_packet, output malformed,
                  input ready);
  modport sink   (input valid, input byte_out, input byte_role, input header_done,
                  input packet_type, input qos_level, input remaining_length,
                  input topic_length, input packet_id, input has_packet_id,
                  input payload_length, input last_of_packet, input malformed,
                  output ready);
endinterface

// ===== rtl/mqtt_header_stream_parser.sv =====
// MQTT header stream parser: tags each stream byte with its role and header fields.
// The result for a byte is registered; it is in the output register the cycle after the byte is accepted.
// One byte per cycle while the output drains; the parse state advances on every accepted request.
// The input stalls only while a result waits in the output register and out is not ready.
// Reset (rst_n low, synchronous) returns the parser to the type byte and empties the output.
module mqtt_header_stream_parser (
  input  logic       clk,
  input  logic       rst_n,
  mhsp_in_if.sink    in_chan,
  mhsp_out_if.source out_chan
);

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  mhsp_pkg::phase_t                phase_r, phase_nxt;
  logic [mhsp_pkg::TYPE_W-1:0]     type_r, type_nxt;
  logic [mhsp_pkg::QOS_W-1:0]      qos_r, qos_nxt;
  logic [mhsp_pkg::LEN_W-1:0]      len_acc_r, len_acc_nxt;
  logic [mhsp_pkg::LCNT_W-1:0]     len_cnt_r, len_cnt_nxt;
  logic [mhsp_pkg::LEN_W-1:0]      bytes_left_r, bytes_left_nxt;
  logic [mhsp_pkg::WORD_W-1:0]     topic_len_r, topic_len_nxt;
  logic [mhsp_pkg::WORD_W-1:0]     topic_left_r, topic_left_nxt;
  logic [mhsp_pkg::WORD_W-1:0]     id_r, id_nxt;
  logic                            sub_r, sub_nxt;
  logic                            bad_r, bad_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  mhsp_pkg::result_t               res_r, res_nxt;

  logic                            in_fire;
  logic [mhsp_pkg::BYTE_W-1:0]     rx;

  // Step-local signals
  mhsp_pkg::role_t                 role;
  logic                            hd;
  logic                            last;
  logic                            is_body;
  mhsp_pkg::phase_t                dest;
  logic [mhsp_pkg::LEN_W-1:0]      len_group;
  logic [mhsp_pkg::WORD_W-1:0]     tl_full;
  logic [mhsp_pkg::NEED_W-1:0]     need_tl;
  logic [mhsp_pkg::NEED_W-1:0]     need;
  logic                            is_pub;
  logic                            tl_known;
  logic                            has_id;
  logic [mhsp_pkg::LEN_W-1:0]      payload;

  assign rx      = in_chan.rx_byte;
  // Accept a new request whenever the output register is free or drains this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire = in_chan.valid && in_chan.ready;

  // Place the 7-bit length group by how many length bytes came before it.
  always_comb begin
    len_group = '0;
    case (len_cnt_r[1:0])
      2'd0:    len_group = {21'd0, rx[6:0] & mhsp_pkg::LEN_GROUP_MASK};
      2'd1:    len_group = {14'd0, rx[6:0] & mhsp_pkg::LEN_GROUP_MASK, 7'd0};
      2'd2:    len_group = {7'd0, rx[6:0] & mhsp_pkg::LEN_GROUP_MASK, 14'd0};
      2'd3:    len_group = {rx[6:0] & mhsp_pkg::LEN_GROUP_MASK, 21'd0};
      default: len_group = '0;
    endcase
  end

  // Bytes a PUBLISH variable header needs once the topic length is complete.
  assign tl_full = {topic_len_r[15:8], rx};
  assign need_tl = mhsp_pkg::NEED_W'(2) + {1'b0, tl_full} +
                   ((qos_r != mhsp_pkg::QOS_NONE) ? mhsp_pkg::NEED_W'(2) : '0);

  // ---------------------------------------------------------------------------
  // Next-state logic for one byte
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt      = phase_r;
    type_nxt       = type_r;
    qos_nxt        = qos_r;
    len_acc_nxt    = len_acc_r;
    len_cnt_nxt    = len_cnt_r;
    bytes_left_nxt = bytes_left_r;
    topic_len_nxt  = topic_len_r;
    topic_left_nxt = topic_left_r;
    id_nxt         = id_r;
    sub_nxt        = sub_r;
    bad_nxt        = bad_r;
    role           = mhsp_pkg::ROLE_OTHER;
    hd             = 1'b0;
    last           = 1'b0;
    dest           = phase_r;
    is_body        = 1'b0;

    case (phase_r)
      mhsp_pkg::PH_TYPE: begin
        // Open a new packet: latch type and QoS, clear everything else.
        role           = mhsp_pkg::ROLE_TYPE;
        type_nxt       = rx[7:4];
        qos_nxt        = rx[2:1];
        len_acc_nxt    = '0;
        len_cnt_nxt    = '0;
        bytes_left_nxt = '0;
        topic_len_nxt  = '0;
        topic_left_nxt = '0;
        id_nxt         = '0;
        sub_nxt        = 1'b0;
        bad_nxt        = 1'b0;
        phase_nxt      = mhsp_pkg::PH_LEN;
      end
      mhsp_pkg::PH_LEN: begin
        role        = mhsp_pkg::ROLE_LEN;
        len_acc_nxt = len_acc_r | len_group;
        len_cnt_nxt = len_cnt_r + 3'd1;
        if (!(rx[7] && (len_cnt_nxt < mhsp_pkg::MAX_LEN_BYTES))) begin
          // Length field ends here; a continuation bit on the last allowed byte is overlong.
          if (rx[7]) begin
            bad_nxt = 1'b1;
          end
          bytes_left_nxt = len_acc_nxt;
          if (type_r == mhsp_pkg::TYPE_PUBLISH) begin
            dest = mhsp_pkg::PH_TLEN;
          end else if (type_r inside {[mhsp_pkg::TYPE_ID_LO : mhsp_pkg::TYPE_ID_HI]}) begin
            dest = mhsp_pkg::PH_ID;
          end else begin
            dest = mhsp_pkg::PH_OTHER;
            hd   = 1'b1;
          end
          sub_nxt = 1'b0;
          if (len_acc_nxt == '0) begin
            // Empty body: this byte ends the packet; a missing variable header is malformed.
            last = 1'b1;
            if (dest != mhsp_pkg::PH_OTHER) begin
              bad_nxt = 1'b1;
              hd      = 1'b1;
            end
            phase_nxt = mhsp_pkg::PH_TYPE;
          end else begin
            phase_nxt = dest;
          end
        end
      end
      mhsp_pkg::PH_TLEN: begin
        is_body = 1'b1;
        role    = mhsp_pkg::ROLE_TLEN;
        if (!sub_r) begin
          topic_len_nxt = {rx, 8'd0};
          sub_nxt       = 1'b1;
        end else begin
          topic_len_nxt  = tl_full;
          sub_nxt        = 1'b0;
          topic_left_nxt = tl_full;
          if ({11'd0, need_tl} > len_acc_r) begin
            bad_nxt = 1'b1;
          end
          if (tl_full != '0) begin
            dest = mhsp_pkg::PH_TOPIC;
          end else if (qos_r != mhsp_pkg::QOS_NONE) begin
            dest = mhsp_pkg::PH_ID;
          end else begin
            dest = mhsp_pkg::PH_PAYLOAD;
            hd   = 1'b1;
          end
        end
      end
      mhsp_pkg::PH_TOPIC: begin
        is_body = 1'b1;
        role    = mhsp_pkg::ROLE_TOPIC;
        if (topic_left_r != '0) begin
          topic_left_nxt = topic_left_r - 16'd1;
        end
        if (topic_left_nxt == '0) begin
          if (qos_r != mhsp_pkg::QOS_NONE) begin
            dest = mhsp_pkg::PH_ID;
          end else begin
            dest = mhsp_pkg::PH_PAYLOAD;
            hd   = 1'b1;
          end
        end
      end
      mhsp_pkg::PH_ID: begin
        is_body = 1'b1;
        role    = mhsp_pkg::ROLE_ID;
        if (!sub_r) begin
          id_nxt  = {rx, 8'd0};
          sub_nxt = 1'b1;
        end else begin
          id_nxt  = {id_r[15:8], rx};
          sub_nxt = 1'b0;
          hd      = 1'b1;
          dest    = (type_r == mhsp_pkg::TYPE_PUBLISH) ? mhsp_pkg::PH_PAYLOAD
                                                       : mhsp_pkg::PH_OTHER;
        end
      end
      mhsp_pkg::PH_PAYLOAD: begin
        is_body = 1'b1;
        role    = mhsp_pkg::ROLE_PAYLOAD;
      end
      default: begin
        is_body = 1'b1;
        role    = mhsp_pkg::ROLE_OTHER;
        dest    = mhsp_pkg::PH_OTHER;
      end
    endcase

    // Count down the body and close the packet when it runs out.
    if (is_body) begin
      if (bytes_left_r != '0) begin
        bytes_left_nxt = bytes_left_r - 28'd1;
      end
      if (bytes_left_nxt == '0) begin
        last = 1'b1;
        if (dest == mhsp_pkg::PH_TLEN || dest == mhsp_pkg::PH_TOPIC ||
            dest == mhsp_pkg::PH_ID) begin
          // Packet ended inside the variable header.
          bad_nxt = 1'b1;
          hd      = 1'b1;
        end
        sub_nxt   = 1'b0;
        phase_nxt = mhsp_pkg::PH_TYPE;
      end else begin
        phase_nxt = dest;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reported fields, taken from the updated state
  // ---------------------------------------------------------------------------
  assign is_pub = (type_nxt == mhsp_pkg::TYPE_PUBLISH);
  assign need   = mhsp_pkg::NEED_W'(2) + {1'b0, topic_len_nxt} +
                  ((qos_nxt != mhsp_pkg::QOS_NONE) ? mhsp_pkg::NEED_W'(2) : '0);
  assign tl_known = is_pub &&
                    (phase_r == mhsp_pkg::PH_TOPIC || phase_r == mhsp_pkg::PH_ID ||
                     phase_r == mhsp_pkg::PH_PAYLOAD ||
                     (phase_r == mhsp_pkg::PH_TLEN && sub_r));
  assign payload  = (tl_known && (len_acc_nxt >= {11'd0, need})) ?
                    (len_acc_nxt - {11'd0, need}) : '0;
  assign has_id   = (type_nxt inside {[mhsp_pkg::TYPE_ID_LO : mhsp_pkg::TYPE_ID_HI]}) ||
                    (is_pub && (qos_nxt != mhsp_pkg::QOS_NONE));

  always_comb begin
    res_nxt.byte_out         = rx;
    res_nxt.byte_role        = role;
    res_nxt.header_done      = hd;
    res_nxt.packet_type      = type_nxt;
    res_nxt.qos_level        = qos_nxt;
    res_nxt.remaining_length = len_acc_nxt;
    res_nxt.topic_length     = topic_len_nxt;
    res_nxt.packet_id        = id_nxt;
    res_nxt.has_packet_id    = has_id;
    res_nxt.payload_length   = payload;
    res_nxt.last_of_packet   = last;
    res_nxt.malformed        = bad_nxt;
  end

  // Hold the result until taken; load a new one on every accepted request.
  assign out_valid_nxt = in_fire || (out_valid_r && !out_chan.ready);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mhsp_pkg::PH_TYPE;
      type_r       <= '0;
      qos_r        <= '0;
      len_acc_r    <= '0;
      len_cnt_r    <= '0;
      bytes_left_r <= '0;
      topic_len_r  <= '0;
      topic_left_r <= '0;
      id_r         <= '0;
      sub_r        <= 1'b0;
      bad_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r      <= phase_nxt;
        type_r       <= type_nxt;
        qos_r        <= qos_nxt;
        len_acc_r    <= len_acc_nxt;
        len_cnt_r    <= len_cnt_nxt;
        bytes_left_r <= bytes_left_nxt;
        topic_len_r  <= topic_len_nxt;
        topic_left_r <= topic_left_nxt;
        id_r         <= id_nxt;
        sub_r        <= sub_nxt;
        bad_r        <= bad_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output channel
  // ---------------------------------------------------------------------------
  assign out_chan.valid            = out_valid_r;
  assign out_chan.byte_out         = res_r.byte_out;
  assign out_chan.byte_role        = res_r.byte_role;
  assign out_chan.header_done      = res_r.header_done;
  assign out_chan.packet_type      = res_r.packet_type;
  assign out_chan.qos_level        = res_r.qos_level;
  assign out_chan.remaining_length = res_r.remaining_length;
  assign out_chan.topic_length     = res_r.topic_length;
  assign out_chan.packet_id        = res_r.packet_id;
  assign out_chan.has_packet_id    = res_r.has_packet_id;
  assign out_chan.payload_length   = res_r.payload_length;
  assign out_chan.last_of_packet   = res_r.last_of_packet;
  assign out_chan.malformed        = res_r.malformed;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_returns_to_type: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> (phase_r == mhsp_pkg::PH_TYPE))
    else $error("packet end did not return to the type byte");

  a_len_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mhsp_pkg::PH_LEN) |-> (len_cnt_r < mhsp_pkg::MAX_LEN_BYTES))
    else $error("length byte count ran past its limit");

  a_type_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.byte_role == mhsp_pkg::ROLE_TYPE) |->
    (res_r.remaining_length == '0 && !res_r.malformed && !res_r.last_of_packet))
    else $error("type byte carried stale packet state");

  a_payload_only_publish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.payload_length != '0) |->
    (res_r.packet_type == mhsp_pkg::TYPE_PUBLISH))
    else $error("payload length reported for a non-PUBLISH packet");

  a_body_has_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != mhsp_pkg::PH_TYPE && phase_r != mhsp_pkg::PH_LEN) |->
    (bytes_left_r != '0))
    else $error("body phase entered with no bytes left");

endmodule
